// File: hdl/abld_pkg.sv
`timescale 1ns / 1ps

package abld_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int TIME_W     = 32;
    localparam int DEBOUNCE_W = 16;
    localparam int CLASS_W    = 3;

    localparam int AVG_SAMPLES_DEF = 4;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(50);

    // Averaged-level windows of the resistor ladder, inclusive bounds.
    localparam int LEFT_MIN   = 228;
    localparam int LEFT_MAX   = 240;
    localparam int CENTER_MIN = 360;
    localparam int CENTER_MAX = 380;
    localparam int RIGHT_MIN  = 455;
    localparam int RIGHT_MAX  = 470;
    localparam int UP_MIN     = 525;
    localparam int UP_MAX     = 545;
    localparam int DOWN_MIN   = 575;
    localparam int DOWN_MAX   = 650;

    typedef enum logic [CLASS_W-1:0] {
        CLS_NONE   = 3'd0,
        CLS_LEFT   = 3'd1,
        CLS_CENTER = 3'd2,
        CLS_RIGHT  = 3'd3,
        CLS_UP     = 3'd4,
        CLS_DOWN   = 3'd5
    } t_class;

    typedef logic [SAMPLE_W-1:0] t_sample;

endpackage

// File: hdl/abld_classify.sv
`timescale 1ns / 1ps

module abld_classify #(
    parameter int AVG_SAMPLES = abld_pkg::AVG_SAMPLES_DEF
) (
    input  abld_pkg::t_sample i_sample_a,
    input  abld_pkg::t_sample i_sample_b,
    input  abld_pkg::t_sample i_sample_c,
    input  abld_pkg::t_sample i_sample_d,
    output abld_pkg::t_class  o_class
);

    localparam int SUM_W = abld_pkg::SAMPLE_W + $clog2(AVG_SAMPLES);

    // The floor of sum / N lies in [lo, hi] exactly when sum lies in [lo*N, hi*N + N - 1].
    localparam logic [SUM_W-1:0] LEFT_LO   = SUM_W'(abld_pkg::LEFT_MIN * AVG_SAMPLES);
    localparam logic [SUM_W-1:0] LEFT_HI   = SUM_W'((abld_pkg::LEFT_MAX + 1) * AVG_SAMPLES - 1);
    localparam logic [SUM_W-1:0] CENTER_LO = SUM_W'(abld_pkg::CENTER_MIN * AVG_SAMPLES);
    localparam logic [SUM_W-1:0] CENTER_HI =
        SUM_W'((abld_pkg::CENTER_MAX + 1) * AVG_SAMPLES - 1);
    localparam logic [SUM_W-1:0] RIGHT_LO  = SUM_W'(abld_pkg::RIGHT_MIN * AVG_SAMPLES);
    localparam logic [SUM_W-1:0] RIGHT_HI  = SUM_W'((abld_pkg::RIGHT_MAX + 1) * AVG_SAMPLES - 1);
    localparam logic [SUM_W-1:0] UP_LO     = SUM_W'(abld_pkg::UP_MIN * AVG_SAMPLES);
    localparam logic [SUM_W-1:0] UP_HI     = SUM_W'((abld_pkg::UP_MAX + 1) * AVG_SAMPLES - 1);
    localparam logic [SUM_W-1:0] DOWN_LO   = SUM_W'(abld_pkg::DOWN_MIN * AVG_SAMPLES);
    localparam logic [SUM_W-1:0] DOWN_HI   = SUM_W'((abld_pkg::DOWN_MAX + 1) * AVG_SAMPLES - 1);

    abld_pkg::t_sample w_smp [4];
    logic [SUM_W-1:0]  w_sum;

    assign w_smp[0] = i_sample_a;
    assign w_smp[1] = i_sample_b;
    assign w_smp[2] = i_sample_c;
    assign w_smp[3] = i_sample_d;

    // The four samples are reused in turn when more than four are averaged.
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < AVG_SAMPLES; k++) begin
            w_sum = w_sum + SUM_W'(w_smp[2'(k)]);
        end
    end

    always_comb begin
        if (w_sum >= LEFT_LO && w_sum <= LEFT_HI) begin
            o_class = abld_pkg::CLS_LEFT;
        end else if (w_sum >= CENTER_LO && w_sum <= CENTER_HI) begin
            o_class = abld_pkg::CLS_CENTER;
        end else if (w_sum >= RIGHT_LO && w_sum <= RIGHT_HI) begin
            o_class = abld_pkg::CLS_RIGHT;
        end else if (w_sum >= UP_LO && w_sum <= UP_HI) begin
            o_class = abld_pkg::CLS_UP;
        end else if (w_sum >= DOWN_LO && w_sum <= DOWN_HI) begin
            o_class = abld_pkg::CLS_DOWN;
        end else begin
            o_class = abld_pkg::CLS_NONE;
        end
    end

endmodule

// File: hdl/analog_button_ladder_debounce_top.sv
`timescale 1ns / 1ps
// Throughput: one poll per cycle while the output is not stalled; the input register feeds the
// averaging, window compare and debounce update, which load the result register.
// Reset (synchronous, active low) empties both registers, clears the debounce
// state and sets the debounce delay to 50 ms.

module analog_button_ladder_debounce_top #(
    parameter int AVG_SAMPLES = abld_pkg::AVG_SAMPLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [abld_pkg::DEBOUNCE_W-1:0]   i_cfg_wr_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [abld_pkg::TIME_W-1:0]       i_now_ms,
    input  logic [abld_pkg::SAMPLE_W-1:0]     i_sample_a,
    input  logic [abld_pkg::SAMPLE_W-1:0]     i_sample_b,
    input  logic [abld_pkg::SAMPLE_W-1:0]     i_sample_c,
    input  logic [abld_pkg::SAMPLE_W-1:0]     i_sample_d,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [abld_pkg::CLASS_W-1:0]      o_button_event,
    output logic [abld_pkg::CLASS_W-1:0]      o_raw_class
);

    logic [abld_pkg::DEBOUNCE_W-1:0] r_debounce_ms;

    logic                          r_in_valid;
    logic [abld_pkg::TIME_W-1:0]   r_now_ms;
    abld_pkg::t_sample             r_sample_a;
    abld_pkg::t_sample             r_sample_b;
    abld_pkg::t_sample             r_sample_c;
    abld_pkg::t_sample             r_sample_d;

    logic                          r_out_valid;
    abld_pkg::t_class              r_button_event;
    abld_pkg::t_class              r_raw_class;

    abld_pkg::t_class              r_stable_class;
    abld_pkg::t_class              r_candidate_class;
    logic                          r_verifying;
    logic [abld_pkg::TIME_W-1:0]   r_change_time;

    abld_pkg::t_class              n_stable_class;
    abld_pkg::t_class              n_candidate_class;
    logic                          n_verifying;
    logic [abld_pkg::TIME_W-1:0]   n_change_time;
    abld_pkg::t_class              n_button_event;

    abld_pkg::t_class              w_class;
    logic [abld_pkg::TIME_W-1:0]   w_elapsed;
    logic                          w_out_load;
    logic                          w_in_load;

    assign w_out_load = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_out_load;
    assign w_in_load  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= abld_pkg::DEBOUNCE_RESET;
        end else if (i_cfg_wr_en) begin
            r_debounce_ms <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_load) begin
            r_in_valid <= 1'b1;
        end else if (w_out_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load) begin
            r_now_ms   <= i_now_ms;
            r_sample_a <= i_sample_a;
            r_sample_b <= i_sample_b;
            r_sample_c <= i_sample_c;
            r_sample_d <= i_sample_d;
        end
    end

    abld_classify #(
        .AVG_SAMPLES (AVG_SAMPLES)
    ) u_classify (
        .i_sample_a (r_sample_a),
        .i_sample_b (r_sample_b),
        .i_sample_c (r_sample_c),
        .i_sample_d (r_sample_d),
        .o_class    (w_class)
    );

    assign w_elapsed = r_now_ms - r_change_time;

    always_comb begin
        n_stable_class    = r_stable_class;
        n_candidate_class = r_candidate_class;
        n_verifying       = r_verifying;
        n_change_time     = r_change_time;
        n_button_event    = abld_pkg::CLS_NONE;
        if (!r_verifying) begin
            // A fresh change has zero elapsed time, so it cannot confirm on the same poll.
            if (w_class != r_stable_class) begin
                n_candidate_class = w_class;
                n_change_time     = r_now_ms;
                n_verifying       = 1'b1;
            end
        end else if (w_elapsed > abld_pkg::TIME_W'(r_debounce_ms)) begin
            if (w_class == r_candidate_class) begin
                n_stable_class = r_candidate_class;
                n_button_event = r_candidate_class;
            end
            n_verifying = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_class    <= abld_pkg::CLS_NONE;
            r_candidate_class <= abld_pkg::CLS_NONE;
            r_verifying       <= 1'b0;
            r_change_time     <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_stable_class    <= n_stable_class;
                r_candidate_class <= n_candidate_class;
                r_verifying       <= n_verifying;
                r_change_time     <= n_change_time;
                r_out_valid       <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid       <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_button_event <= n_button_event;
            r_raw_class    <= w_class;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_button_event = r_button_event;
    assign o_raw_class    = r_raw_class;

endmodule

// File: hdl/abld_checker.sv
`timescale 1ns / 1ps

module abld_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [abld_pkg::CLASS_W-1:0]      o_button_event,
    input logic [abld_pkg::CLASS_W-1:0]      o_raw_class
);

    // A result beat held by stall keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_button_event) && $stable(o_raw_class))
        else $error("result beat changed while stalled");

    // A confirmed button is always the class seen on the same poll.
    a_event_matches_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_button_event != abld_pkg::CLS_NONE |->
            o_button_event == o_raw_class)
        else $error("button event differs from raw class");

    // A confirmation ends verification, so the next poll cannot confirm again.
    a_no_double_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_button_event != abld_pkg::CLS_NONE ##1 o_out_valid
            |-> o_button_event == abld_pkg::CLS_NONE)
        else $error("two confirmations on consecutive polls");

    // No result beat is shown right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind analog_button_ladder_debounce_top abld_checker u_abld_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_button_event (o_button_event),
    .o_raw_class    (o_raw_class)
);
